[hdl/mpqs_pkg.sv]
// ----------------------------------------------------------------------------
// mpqs_pkg
// Types and codes shared by the stable max-priority queue.
// ----------------------------------------------------------------------------
package mpqs_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] entry_id;
		logic [15:0] wait_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] removed_id;
		logic [15:0] removed_wait;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] wt;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

[hdl/mpqs_cell.sv]
// ----------------------------------------------------------------------------
// mpqs_cell
// One queue slot: holds an entry, forwards the running maximum toward the
// tail one slot per cycle, and shifts toward the head on a remove.
// ----------------------------------------------------------------------------
module mpqs_cell #(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mpqs_pkg::cell_ctl_t        ctl,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  logic [$clog2(DEPTH)-1:0]   sel_idx,
	input  mpqs_pkg::entry_t           ins_ent,
	input  mpqs_pkg::entry_t           next_ent,
	input  logic                       prev_found,
	input  mpqs_pkg::entry_t           prev_best,
	input  logic [$clog2(DEPTH)-1:0]   prev_idx,
	output mpqs_pkg::entry_t           ent,
	output logic                       best_found,
	output mpqs_pkg::entry_t           best,
	output logic [$clog2(DEPTH)-1:0]   best_idx
);

	localparam int CW = $clog2(DEPTH+1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [IW-1:0] IDX_I = IW'(IDX);

	mpqs_pkg::entry_t ent_q;
	mpqs_pkg::entry_t best_q;
	logic [IW-1:0]    best_idx_q;
	logic             best_found_q;
	logic             valid;
	logic             take_self;

	assign valid     = count > IDX_C;
	assign take_self = valid && (!prev_found || ent_q.wt > prev_best.wt);

	always_ff @(posedge clk) begin
		if (ctl.load && count == IDX_C) begin
			ent_q <= ins_ent;
		end else if (ctl.shift && IDX_I >= sel_idx) begin
			ent_q <= next_ent;
		end
		if (take_self) begin
			best_q     <= ent_q;
			best_idx_q <= IDX_I;
		end else begin
			best_q     <= prev_best;
			best_idx_q <= prev_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else begin
			best_found_q <= take_self || prev_found;
		end
	end

	assign ent        = ent_q;
	assign best       = best_q;
	assign best_idx   = best_idx_q;
	assign best_found = best_found_q;

endmodule

[hdl/max_priority_queue_stable_top.sv]
// ----------------------------------------------------------------------------
// max_priority_queue_stable_top
// Bounded queue in arrival order; remove returns the oldest max-wait entry.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   request  | req_valid / req_ready  | req  (operation, id, wait)
//   response | rsp_valid / rsp_ready  | rsp  (status, id, wait, occ)
//
// Insert and empty remove go from IDLE to DONE. Remove runs SCAN, SHIFT, DONE;
// SCAN lasts while the running maximum walks the slot chain one slot per cycle.
// Slot contents are undefined after reset; count, state and flags are cleared.
// A waiting response sits in an output register; a new request is taken
// once the previous result has moved into it.
// ----------------------------------------------------------------------------
module max_priority_queue_stable_top #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mpqs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mpqs_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH+1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_C = IW'(DEPTH-1);

	mpqs_pkg::state_t    state_q, state_d;
	mpqs_pkg::cell_ctl_t ctl;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       scan_q;
	logic                accept;
	logic                push;
	logic [1:0]          res_status_q;
	mpqs_pkg::entry_t    res_ent_q;
	mpqs_pkg::rsp_t      rsp_q;
	logic                rsp_valid_q;
	logic [31:0]         occ_w;
	mpqs_pkg::entry_t    ins_ent;

	mpqs_pkg::entry_t    ent      [DEPTH];
	mpqs_pkg::entry_t    best     [DEPTH];
	logic [IW-1:0]       best_idx [DEPTH];
	logic                best_fnd [DEPTH];

	assign accept     = req_valid && req_ready;
	assign ins_ent.id = req.entry_id;
	assign ins_ent.wt = req.wait_time;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpqs_pkg::S_IDLE: begin
				if (accept) begin
					if (req.operation == mpqs_pkg::OP_REMOVE && cnt_q != '0) begin
						state_d = mpqs_pkg::S_SCAN;
					end else begin
						state_d = mpqs_pkg::S_DONE;
					end
				end
			end
			mpqs_pkg::S_SCAN: begin
				if (scan_q == LAST_C) begin
					state_d = mpqs_pkg::S_SHIFT;
				end
			end
			mpqs_pkg::S_SHIFT: begin
				state_d = mpqs_pkg::S_DONE;
			end
			mpqs_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = mpqs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpqs_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		ctl.load  = 1'b0;
		ctl.shift = 1'b0;
		push      = 1'b0;
		case (state_q)
			mpqs_pkg::S_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = accept && req.operation == mpqs_pkg::OP_INSERT
					&& cnt_q != FULL_C;
			end
			mpqs_pkg::S_SHIFT: begin
				ctl.shift = 1'b1;
			end
			mpqs_pkg::S_DONE: begin
				push = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpqs_pkg::S_IDLE;
			cnt_q       <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.shift) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == mpqs_pkg::S_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end else begin
				scan_q <= '0;
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign occ_w = 32'(cnt_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			res_ent_q <= '0;
			if (req.operation == mpqs_pkg::OP_INSERT) begin
				res_status_q <= (cnt_q == FULL_C) ? mpqs_pkg::ST_FULL : mpqs_pkg::ST_DONE;
			end else begin
				res_status_q <= (cnt_q == '0) ? mpqs_pkg::ST_EMPTY : mpqs_pkg::ST_DONE;
			end
		end else if (ctl.shift) begin
			res_ent_q <= best[DEPTH-1];
		end
		if (push) begin
			rsp_q.status       <= res_status_q;
			rsp_q.removed_id   <= res_ent_q.id;
			rsp_q.removed_wait <= res_ent_q.wt;
			rsp_q.occupancy    <= occ_w[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             prev_found;
		mpqs_pkg::entry_t prev_best;
		logic [IW-1:0]    prev_idx;
		mpqs_pkg::entry_t next_ent;

		if (i == 0) begin : g_head
			assign prev_found = 1'b0;
			assign prev_best  = '0;
			assign prev_idx   = '0;
		end else begin : g_body
			assign prev_found = best_fnd[i-1];
			assign prev_best  = best[i-1];
			assign prev_idx   = best_idx[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign next_ent = ent[i];
		end else begin : g_mid
			assign next_ent = ent[i+1];
		end

		mpqs_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (cnt_q),
			.sel_idx   (best_idx[DEPTH-1]),
			.ins_ent   (ins_ent),
			.next_ent  (next_ent),
			.prev_found(prev_found),
			.prev_best (prev_best),
			.prev_idx  (prev_idx),
			.ent       (ent[i]),
			.best_found(best_fnd[i]),
			.best      (best[i]),
			.best_idx  (best_idx[i])
		);
	end

endmodule
